/* rtl/dsra_pkg.sv */
// Shared constants and controller/datapath interface types for the seat arbiter.
`timescale 1ns / 1ps
package dsra_pkg;

  localparam int NUM_SEATS_DEF = 5;

  // Fixed field widths
  localparam int SEAT_W   = 3;
  localparam int ST_W     = 2;
  localparam int EV_W     = 3;
  localparam int STRAT_W  = 2;
  localparam int STATES_W = 10;
  localparam int OWNERS_W = 15;
  localparam int OWN_OUT_W = 3;
  localparam int PACK_SEATS = 5;

  // Seat states
  localparam logic [ST_W-1:0] ST_THINK  = 2'd0;
  localparam logic [ST_W-1:0] ST_HUNGRY = 2'd1;
  localparam logic [ST_W-1:0] ST_EAT    = 2'd2;

  // Result events
  localparam logic [EV_W-1:0] EV_RESET    = 3'd0;
  localparam logic [EV_W-1:0] EV_RELEASED = 3'd1;
  localparam logic [EV_W-1:0] EV_EATING   = 3'd2;
  localparam logic [EV_W-1:0] EV_WAITING  = 3'd3;
  localparam logic [EV_W-1:0] EV_BLOCKED  = 3'd4;

  // Strategy register codes
  localparam logic [STRAT_W-1:0] STRAT_NAIVE = 2'd0;
  localparam logic [STRAT_W-1:0] STRAT_ASYM  = 2'd1;
  localparam logic [STRAT_W-1:0] STRAT_ARB   = 2'd2;

  // Request kinds
  localparam logic ACT_TRIGGER = 1'b0;
  localparam logic ACT_CLEAR   = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE     = 2'd0,
    OP_EXEC     = 2'd1,
    OP_ARB_PREV = 2'd2,
    OP_ARB_NEXT = 2'd3
  } op_e;

  typedef struct packed {
    logic load_item;
    op_e  op;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic arb_rel;
  } sts_t;

endpackage

/* rtl/dsra_datapath.sv */
// Seat/resource table, strategy register, update logic and output register.
`timescale 1ns / 1ps
module dsra_datapath #(
  parameter int NUM_SEATS = dsra_pkg::NUM_SEATS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dsra_pkg::STRAT_W-1:0]     cfg_wdata_i,
  input  logic                             in_action_i,
  input  logic [dsra_pkg::SEAT_W-1:0]      in_seat_i,
  input  dsra_pkg::cmd_t                   cmd_i,
  output dsra_pkg::sts_t                   sts_o,
  output logic [dsra_pkg::EV_W-1:0]        out_event_o,
  output logic [dsra_pkg::STATES_W-1:0]    out_states_o,
  output logic [dsra_pkg::OWNERS_W-1:0]    out_owners_o,
  output logic                             out_deadlock_o
);

  localparam int IDX_W = (NUM_SEATS > 1) ? $clog2(NUM_SEATS) : 1;
  localparam int OWN_W = $clog2(NUM_SEATS + 1);
  localparam logic [dsra_pkg::SEAT_W:0] N_EXT = (dsra_pkg::SEAT_W + 1)'(NUM_SEATS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SEATS - 1);

  logic [dsra_pkg::STRAT_W-1:0] strategy_q;
  logic                         action_q;
  logic [dsra_pkg::SEAT_W-1:0]  seat_q;
  logic [dsra_pkg::ST_W-1:0]    st_q [NUM_SEATS];
  logic [dsra_pkg::ST_W-1:0]    st_d [NUM_SEATS];
  logic [OWN_W-1:0]             own_q [NUM_SEATS];
  logic [OWN_W-1:0]             own_d [NUM_SEATS];
  logic [dsra_pkg::EV_W-1:0]    ev_q, ev_d;

  logic [dsra_pkg::EV_W-1:0]     ev_out_q;
  logic [dsra_pkg::STATES_W-1:0] states_out_q, states_pack;
  logic [dsra_pkg::OWNERS_W-1:0] owners_out_q, owners_pack;
  logic                          dl_out_q, deadlock;

  function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] i);
    nxt = (i == LAST_IDX) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] prv(input logic [IDX_W-1:0] i);
    prv = (i == '0) ? LAST_IDX : i - IDX_W'(1);
  endfunction

  logic             in_range;
  logic [IDX_W-1:0] s_idx, nx_idx, pv_idx, first_idx, second_idx, tgt_idx;
  logic [OWN_W-1:0] me, tgt_me;
  logic             arb_ok, tgt_ok;

  always_comb begin
    in_range = {1'b0, seat_q} < N_EXT;
    s_idx    = seat_q[IDX_W-1:0];
    nx_idx   = nxt(s_idx);
    pv_idx   = prv(s_idx);
    me       = OWN_W'(s_idx) + OWN_W'(1);
    // odd seats reach right first under the asymmetric scheme
    if (strategy_q == dsra_pkg::STRAT_ASYM && s_idx[0]) begin
      first_idx  = nx_idx;
      second_idx = s_idx;
    end else begin
      first_idx  = s_idx;
      second_idx = nx_idx;
    end
    arb_ok  = (st_q[pv_idx] != dsra_pkg::ST_EAT) && (st_q[nx_idx] != dsra_pkg::ST_EAT);
    tgt_idx = (cmd_i.op == dsra_pkg::OP_ARB_PREV) ? pv_idx : nx_idx;
    tgt_me  = OWN_W'(tgt_idx) + OWN_W'(1);
    tgt_ok  = (st_q[tgt_idx] == dsra_pkg::ST_HUNGRY) &&
              (st_q[prv(tgt_idx)] != dsra_pkg::ST_EAT) &&
              (st_q[nxt(tgt_idx)] != dsra_pkg::ST_EAT);
  end

  assign sts_o.arb_rel = (action_q == dsra_pkg::ACT_TRIGGER) && in_range &&
                         (st_q[s_idx] == dsra_pkg::ST_EAT) &&
                         (strategy_q == dsra_pkg::STRAT_ARB);

  always_comb begin
    st_d  = st_q;
    own_d = own_q;
    ev_d  = ev_q;
    case (cmd_i.op)
      dsra_pkg::OP_EXEC: begin
        if (action_q == dsra_pkg::ACT_CLEAR) begin
          for (int k = 0; k < NUM_SEATS; k++) begin
            st_d[k]  = dsra_pkg::ST_THINK;
            own_d[k] = '0;
          end
          ev_d = dsra_pkg::EV_RESET;
        end else if (!in_range) begin
          ev_d = dsra_pkg::EV_BLOCKED;
        end else if (st_q[s_idx] == dsra_pkg::ST_EAT) begin
          st_d[s_idx]   = dsra_pkg::ST_THINK;
          own_d[s_idx]  = '0;
          own_d[nx_idx] = '0;
          ev_d          = dsra_pkg::EV_RELEASED;
        end else begin
          st_d[s_idx] = dsra_pkg::ST_HUNGRY;
          case (strategy_q)
            dsra_pkg::STRAT_NAIVE, dsra_pkg::STRAT_ASYM: begin
              if (own_q[first_idx] != me && own_q[first_idx] != '0) begin
                ev_d = dsra_pkg::EV_BLOCKED;
              end else begin
                own_d[first_idx] = me;
                if (own_q[second_idx] == '0) begin
                  own_d[second_idx] = me;
                  st_d[s_idx]       = dsra_pkg::ST_EAT;
                  ev_d              = dsra_pkg::EV_EATING;
                end else begin
                  ev_d = dsra_pkg::EV_WAITING;
                end
              end
            end
            dsra_pkg::STRAT_ARB: begin
              if (arb_ok) begin
                st_d[s_idx]   = dsra_pkg::ST_EAT;
                own_d[s_idx]  = me;
                own_d[nx_idx] = me;
                ev_d          = dsra_pkg::EV_EATING;
              end else begin
                ev_d = dsra_pkg::EV_BLOCKED;
              end
            end
            default: ev_d = dsra_pkg::EV_BLOCKED;
          endcase
        end
      end
      dsra_pkg::OP_ARB_PREV, dsra_pkg::OP_ARB_NEXT: begin
        // neighbor regrant after a release
        if (tgt_ok) begin
          st_d[tgt_idx]        = dsra_pkg::ST_EAT;
          own_d[tgt_idx]       = tgt_me;
          own_d[nxt(tgt_idx)]  = tgt_me;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strategy_q <= dsra_pkg::STRAT_NAIVE;
      for (int k = 0; k < NUM_SEATS; k++) begin
        st_q[k]  <= dsra_pkg::ST_THINK;
        own_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      strategy_q <= cfg_wdata_i;
      for (int k = 0; k < NUM_SEATS; k++) begin
        st_q[k]  <= dsra_pkg::ST_THINK;
        own_q[k] <= '0;
      end
    end else begin
      st_q  <= st_d;
      own_q <= own_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
    if (cmd_i.load_item) begin
      action_q <= in_action_i;
      seat_q   <= in_seat_i;
    end
  end

  always_comb begin
    logic all_hungry, all_held;
    all_hungry  = 1'b1;
    all_held    = 1'b1;
    states_pack = '0;
    owners_pack = '0;
    for (int k = 0; k < NUM_SEATS; k++) begin
      if (st_q[k] != dsra_pkg::ST_HUNGRY) all_hungry = 1'b0;
      if (own_q[k] == '0) all_held = 1'b0;
    end
    // only the first five seats fit the packed fields
    for (int k = 0; k < dsra_pkg::PACK_SEATS; k++) begin
      if (k < NUM_SEATS) begin
        states_pack[2*k +: 2] = st_q[k];
        owners_pack[3*k +: 3] = dsra_pkg::OWN_OUT_W'(own_q[k]);
      end
    end
    // every seat hungry already rules out an eating seat
    deadlock = all_hungry && all_held;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      ev_out_q     <= ev_q;
      states_out_q <= states_pack;
      owners_out_q <= owners_pack;
      dl_out_q     <= deadlock;
    end
  end

  assign out_event_o    = ev_out_q;
  assign out_states_o   = states_out_q;
  assign out_owners_o   = owners_out_q;
  assign out_deadlock_o = dl_out_q;

endmodule

/* rtl/dsra_ctrl.sv */
// Sequencing state machine for request accept, update steps and result hand-off.
`timescale 1ns / 1ps
module dsra_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  input  dsra_pkg::sts_t sts_i,
  output dsra_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_ARB_L = 5'b00100,
    S_ARB_R = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;

  assign out_free   = !out_vld_q || m_tready_i;
  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = out_vld_q;

  always_comb begin
    state_d         = state_q;
    out_vld_d       = out_vld_q && !m_tready_i;
    cmd_o.load_item = 1'b0;
    cmd_o.op        = dsra_pkg::OP_NONE;
    cmd_o.load_out  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.op = dsra_pkg::OP_EXEC;
        state_d  = sts_i.arb_rel ? S_ARB_L : S_EMIT;
      end
      S_ARB_L: begin
        cmd_o.op = dsra_pkg::OP_ARB_PREV;
        state_d  = S_ARB_R;
      end
      S_ARB_R: begin
        cmd_o.op = dsra_pkg::OP_ARB_NEXT;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        // hold here until the output register can take the result
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_vld_d      = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_vld_q || m_tready_i))
    else $error("result register overwritten while still pending");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> (state_q == S_EXEC))
    else $error("accepted request not executed next cycle");

  a_rel_regrant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && sts_i.arb_rel) |=> (state_q == S_ARB_L) ##1 (state_q == S_ARB_R))
    else $error("arbitrator release skipped neighbor regrant");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> m_tvalid_o)
    else $error("loaded result not presented");

endmodule

/* rtl/dining_seat_resource_arbiter.sv */
// Top level of the dining seat resource arbiter: stream ports, config port, controller + datapath.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  s_axis   | s_axis_tvalid_i/tready_o   | tuser: action; tdata: seat
//  m_axis   | m_axis_tvalid_o/tready_i   | tuser: event_res; tdata: states, owners, deadlock
//  cfg      | cfg_we_i                   | cfg_wdata_i: strategy (clears the table)
//
// A request passes from accept through the update step to the result load; when an eating
// seat releases under the arbitrator strategy, the previous and next neighbor regrants
// follow the update, each one more pass through the single table update unit.
// Reset clears the table, the strategy register and the result valid.
// A stalled result holds in the output register; the next request is accepted meanwhile
// and waits in the load step until the register is free.
`timescale 1ns / 1ps
module dining_seat_resource_arbiter #(
  parameter int NUM_SEATS = dsra_pkg::NUM_SEATS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,   // [2:0] seat, [7:3] zero
  input  logic                         s_axis_tuser_i,   // [0] action
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [9:0] seat_states, [24:10] resource_owners, [25] deadlock, [31:26] zero
  output logic [31:0]                  m_axis_tdata_o,
  output logic [dsra_pkg::EV_W-1:0]    m_axis_tuser_o,   // [2:0] event_res
  input  logic                         cfg_we_i,
  input  logic [dsra_pkg::STRAT_W-1:0] cfg_wdata_i
);

  dsra_pkg::cmd_t                cmd;
  dsra_pkg::sts_t                sts;
  logic [dsra_pkg::STATES_W-1:0] states;
  logic [dsra_pkg::OWNERS_W-1:0] owners;
  logic                          deadlock;

  dsra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dsra_datapath #(
    .NUM_SEATS (NUM_SEATS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_action_i    (s_axis_tuser_i),
    .in_seat_i      (s_axis_tdata_i[dsra_pkg::SEAT_W-1:0]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_event_o    (m_axis_tuser_o),
    .out_states_o   (states),
    .out_owners_o   (owners),
    .out_deadlock_o (deadlock)
  );

  assign m_axis_tdata_o = {6'd0, deadlock, owners, states};

endmodule
